// ----- hw/rtl/dda_pkg.sv -----
// ----------------------------------------------------------------------------
// DDA line rasterizer package
// Shared widths, beat payload types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package dda_pkg;

  localparam int COORD_BITS   = 9;
  localparam int FRAC_BITS    = 16;
  // Position in Q(COORD).(FRAC); also the width of the divider numerator.
  localparam int ACC_BITS     = COORD_BITS + FRAC_BITS;
  // Signed increment, one bit wider than the position.
  localparam int INC_BITS     = ACC_BITS + 1;
  localparam int DIV_CNT_BITS = $clog2(ACC_BITS);

  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  typedef struct packed {
    logic                  req_type;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
  } dda_req_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;
  } dda_pix_t;

  typedef struct packed {
    logic load_line;
    logic advance;
    logic div_run;
    logic div_finish;
  } dda_cmd_t;

  typedef struct packed {
    logic line_active;
    logic div_last;
    logic out_free;
  } dda_sts_t;

endpackage

// ----- hw/rtl/dda_ctrl.sv -----
// ----------------------------------------------------------------------------
// DDA controller
// Sequences line set-up (increment division) and per-pixel advances.
// ----------------------------------------------------------------------------
module dda_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_type,
  output logic              req_stall,
  input  dda_pkg::dda_sts_t sts,
  output dda_pkg::dda_cmd_t cmd
);
  import dda_pkg::*;

  typedef enum logic [2:0] {
    S_READY  = 3'b001,
    S_DIVIDE = 3'b010,
    S_SIGN   = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;

  assign take = (state == S_READY) && sts.out_free && req_valid;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    req_stall      = 1'b1;
    unique case (state)
      S_READY: begin
        req_stall     = !sts.out_free;
        cmd.load_line = take && (req_type == REQ_START);
        cmd.advance   = take && (req_type == REQ_ADVANCE) && sts.line_active;
        if (cmd.load_line) begin
          state_next = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        cmd.div_run = 1'b1;
        if (sts.div_last) begin
          state_next = S_SIGN;
        end
      end
      S_SIGN: begin
        cmd.div_finish = 1'b1;
        state_next     = S_READY;
      end
      default: begin
        state_next = S_READY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_READY;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hw/rtl/dda_datapath.sv -----
// ----------------------------------------------------------------------------
// DDA datapath
// Endpoint latch, bit-serial increment dividers, accumulators, output register.
// ----------------------------------------------------------------------------
module dda_datapath (
  input  logic              clk,
  input  logic              rst,
  input  dda_pkg::dda_req_t req,
  input  dda_pkg::dda_cmd_t cmd,
  output dda_pkg::dda_sts_t sts,
  output logic              pix_valid,
  input  logic              pix_stall,
  output dda_pkg::dda_pix_t pix
);
  import dda_pkg::*;

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic [COORD_BITS-1:0]      ax;
  logic [COORD_BITS-1:0]      ay;
  logic [COORD_BITS-1:0]      step_in;

  logic [COORD_BITS-1:0]   step_r;
  logic                    neg_x;
  logic                    neg_y;
  logic [ACC_BITS-1:0]     num_x;
  logic [ACC_BITS-1:0]     num_y;
  logic [COORD_BITS-1:0]   rem_x;
  logic [COORD_BITS-1:0]   rem_y;
  logic [DIV_CNT_BITS-1:0] div_cnt;

  logic [COORD_BITS:0]   trial_x;
  logic [COORD_BITS:0]   trial_y;
  logic                  ge_x;
  logic                  ge_y;

  logic [ACC_BITS-1:0]   x_accum;
  logic [ACC_BITS-1:0]   y_accum;
  logic [ACC_BITS-1:0]   x_accum_next;
  logic [ACC_BITS-1:0]   y_accum_next;
  logic [INC_BITS-1:0]   x_step_inc;
  logic [INC_BITS-1:0]   y_step_inc;
  logic [COORD_BITS-1:0] steps_left;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;
  logic                  line_active;
  logic                  final_step;

  // Line set-up from the incoming endpoints.
  assign dx      = $signed({1'b0, req.x_end}) - $signed({1'b0, req.x_start});
  assign dy      = $signed({1'b0, req.y_end}) - $signed({1'b0, req.y_start});
  assign ax      = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
  assign ay      = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
  assign step_in = (ax > ay) ? ax : ay;

  // Restoring division, one quotient bit per cycle; quotient shifts into num.
  assign trial_x = {rem_x, num_x[ACC_BITS-1]};
  assign trial_y = {rem_y, num_y[ACC_BITS-1]};
  assign ge_x    = trial_x >= {1'b0, step_r};
  assign ge_y    = trial_y >= {1'b0, step_r};

  assign x_accum_next = x_accum + x_step_inc[ACC_BITS-1:0];
  assign y_accum_next = y_accum + y_step_inc[ACC_BITS-1:0];
  assign final_step   = (steps_left == COORD_BITS'(1));

  always_ff @(posedge clk) begin
    if (cmd.load_line) begin
      step_r  <= step_in;
      neg_x   <= dx[COORD_BITS];
      neg_y   <= dy[COORD_BITS];
      num_x   <= {ax, {FRAC_BITS{1'b0}}};
      num_y   <= {ay, {FRAC_BITS{1'b0}}};
      rem_x   <= '0;
      rem_y   <= '0;
      div_cnt <= '0;
    end else if (cmd.div_run) begin
      num_x   <= {num_x[ACC_BITS-2:0], ge_x};
      num_y   <= {num_y[ACC_BITS-2:0], ge_y};
      rem_x   <= ge_x ? COORD_BITS'(trial_x - {1'b0, step_r}) : trial_x[COORD_BITS-1:0];
      rem_y   <= ge_y ? COORD_BITS'(trial_y - {1'b0, step_r}) : trial_y[COORD_BITS-1:0];
      div_cnt <= div_cnt + DIV_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_accum     <= '0;
      y_accum     <= '0;
      x_step_inc  <= '0;
      y_step_inc  <= '0;
      steps_left  <= '0;
      end_x       <= '0;
      end_y       <= '0;
      line_active <= 1'b0;
    end else begin
      if (cmd.load_line) begin
        x_accum     <= {req.x_start, {FRAC_BITS{1'b0}}};
        y_accum     <= {req.y_start, {FRAC_BITS{1'b0}}};
        end_x       <= req.x_end;
        end_y       <= req.y_end;
        steps_left  <= step_in;
        line_active <= (step_in != '0);
        x_step_inc  <= '0;
        y_step_inc  <= '0;
      end else if (cmd.div_finish) begin
        x_step_inc <= neg_x ? -{1'b0, num_x} : {1'b0, num_x};
        y_step_inc <= neg_y ? -{1'b0, num_y} : {1'b0, num_y};
      end else if (cmd.advance) begin
        x_accum    <= x_accum_next;
        y_accum    <= y_accum_next;
        steps_left <= steps_left - COORD_BITS'(1);
        if (final_step) begin
          line_active <= 1'b0;
        end
      end
    end
  end

  // Output register: hold while stalled, drop once the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (cmd.load_line || cmd.advance) begin
      pix_valid <= 1'b1;
    end else if (!pix_stall) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_line) begin
      pix.pixel_x    <= req.x_start;
      pix.pixel_y    <= req.y_start;
      pix.last_pixel <= (step_in == '0);
    end else if (cmd.advance) begin
      if (final_step) begin
        pix.pixel_x    <= end_x;
        pix.pixel_y    <= end_y;
        pix.last_pixel <= 1'b1;
      end else begin
        // Floor of a two's complement Q value is its integer bit field.
        pix.pixel_x    <= x_accum_next[ACC_BITS-1:FRAC_BITS];
        pix.pixel_y    <= y_accum_next[ACC_BITS-1:FRAC_BITS];
        pix.last_pixel <= 1'b0;
      end
    end
  end

  assign sts.line_active = line_active;
  assign sts.div_last    = (div_cnt == DIV_CNT_BITS'(ACC_BITS - 1));
  assign sts.out_free    = !pix_valid || !pix_stall;

endmodule

// ----- hw/rtl/dda_line_rasterizer_unit.sv -----
// ----------------------------------------------------------------------------
// DDA line rasterizer
// Walks a line between two endpoints in Q9.16 fixed point, one pixel a beat.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req): a start beat (req_type 0)
//   carries both endpoints; an advance beat (req_type 1) steps the line once.
//   pix channel (pix_valid / pix_stall / pix): one pixel beat per start and
//   per advance of an active line; the line's end point has last_pixel set.
//   An advance with no active line is taken and produces no beat.
// Output: every pixel beat appears in the cycle after its request beat is taken.
// Throughput: advances are taken one per cycle while the output is not stalled.
//   A start is accepted, then the serial x/y increment dividers run at one
//   quotient bit per cycle, then the sign is applied, before the next beat is taken.
// Zero-length line: the start beat gives a single pixel marked last.
// Stall: the output register holds its beat while pix_stall is high; a new
//   request is taken in the cycle that beat leaves, so no bubble is added.
// Reset (rst, synchronous): clears the line state and the output valid; the
//   block comes up idle and ready for a start beat.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  dda_pkg::dda_req_t req,
  output logic              pix_valid,
  input  logic              pix_stall,
  output dda_pkg::dda_pix_t pix
);
  import dda_pkg::*;

  dda_cmd_t cmd;
  dda_sts_t sts;

  // Sequence set-up and advances.
  dda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req.req_type),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Divide, accumulate and register the pixel beat.
  dda_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix)
  );

  // A start always leaves a pixel beat in the output register.
  a_start_emits : assert property (@(posedge clk) disable iff (rst)
    cmd.load_line |=> pix_valid)
    else $error("start beat produced no pixel");

  // No request beat is taken while the increments are being divided.
  a_start_blocks : assert property (@(posedge clk) disable iff (rst)
    cmd.load_line |=> req_stall)
    else $error("request taken during line set-up");

  // Advances step only an active line.
  a_advance_active : assert property (@(posedge clk) disable iff (rst)
    cmd.advance |-> sts.line_active)
    else $error("advance issued with no active line");

  // At most one datapath command per cycle.
  a_cmd_onehot : assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_line, cmd.advance, cmd.div_run, cmd.div_finish}))
    else $error("conflicting datapath commands");

endmodule
